@@ rtl/core/id3tfe_pkg.sv @@
// Package for the ID3v2 text frame extractor: payload structs, status and
// phase codes, byte constants. No dependencies.
`timescale 1ns / 1ps

package id3tfe_pkg;

  localparam int unsigned AddrW = 3;

  localparam logic [7:0]  CharI        = 8'h49;
  localparam logic [7:0]  CharD        = 8'h44;
  localparam logic [7:0]  Char3        = 8'h33;
  localparam logic [7:0]  MajorFour    = 8'h04;
  localparam logic [6:0]  SyncMask     = 7'h7F;
  localparam logic [31:0] TargetIdTit2 = 32'h54495432;
  localparam logic [31:0] TargetIdTpe1 = 32'h54504531;
  localparam logic [31:0] TargetReset  = TargetIdTit2;

  localparam logic [3:0]  HdrMagic0    = 4'd0;
  localparam logic [3:0]  HdrMagic1    = 4'd1;
  localparam logic [3:0]  HdrMagic2    = 4'd2;
  localparam logic [3:0]  HdrMajor     = 4'd3;
  localparam logic [3:0]  HdrSize0     = 4'd6;
  localparam logic [3:0]  HdrLast      = 4'd9;

  localparam logic [3:0]  FhIdFirst    = 4'd0;
  localparam logic [3:0]  FhIdEnd      = 4'd4;
  localparam logic [3:0]  FhSizeEnd    = 4'd8;
  localparam logic [3:0]  FhFlagLast   = 4'd9;
  localparam logic [27:0] FrameHdrLen  = 28'd10;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_TAG    = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_TAG    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       done_res;
    status_e    status;
  } out_item_t;

endpackage

@@ rtl/core/id3tfe_cfg.sv @@
// APB register file for the extractor: holds target_frame_id.
// Depends on id3tfe_pkg.
`timescale 1ns / 1ps

module id3tfe_cfg import id3tfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [31:0]      target_o
);

  logic [31:0] target_q, target_d;
  logic        wr_en;

  assign pready = 1'b1;
  // register index is paddr[2]; only index zero exists
  assign wr_en  = psel & penable & pwrite & ~paddr[2];

  always_comb begin
    target_d = target_q;
    if (wr_en) begin
      target_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else begin
      target_q <= target_d;
    end
  end

  assign prdata   = paddr[2] ? 32'd0 : target_q;
  assign target_o = target_q;

endmodule

@@ rtl/core/id3tfe_parser.sv @@
// Header check and frame walk: parser state plus the per-byte next-state and
// result logic. Depends on id3tfe_pkg.
`timescale 1ns / 1ps

module id3tfe_parser import id3tfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  in_item_t    item_i,
  input  logic [31:0] target_i,
  output out_item_t   res_o,
  output logic        res_valid_o
);

  phase_e      phase_q, phase_d, phase_e_w;
  logic [3:0]  hdr_idx_q, hdr_idx_d, hdr_idx_e;
  logic        major4_q, major4_d, major4_e;
  logic [27:0] tag_len_q, tag_len_d, tag_len_e;
  logic [27:0] tag_pos_q, tag_pos_d, tag_pos_e;
  logic [27:0] fr_off_q, fr_off_d, fr_off_e;
  logic [3:0]  fh_idx_q, fh_idx_d, fh_idx_e;
  logic [31:0] fr_id_q, fr_id_d, fr_id_e;
  logic [31:0] fr_len_q, fr_len_d, fr_len_e;
  logic [31:0] body_q, body_d, body_e;
  logic        match_q, match_d, match_e;
  logic        txt_stop_q, txt_stop_d, txt_stop_e;
  logic        found_q, found_d, found_e;
  logic        scan_stop_q, scan_stop_d, scan_stop_e;

  logic        start, active, done, tv, bad_magic;
  logic [7:0]  b;
  status_e     st;
  logic [28:0] pos_plus10;
  logic [27:0] limit;

  assign start = item_i.file_start;
  assign b     = item_i.data_byte;

  // a start byte sees the cleared per-file state
  always_comb begin
    phase_e_w   = start ? PH_HEADER : phase_q;
    hdr_idx_e   = start ? 4'd0  : hdr_idx_q;
    major4_e    = start ? 1'b0  : major4_q;
    tag_len_e   = start ? 28'd0 : tag_len_q;
    tag_pos_e   = start ? 28'd0 : tag_pos_q;
    fr_off_e    = start ? 28'd0 : fr_off_q;
    fh_idx_e    = start ? 4'd0  : fh_idx_q;
    fr_id_e     = start ? 32'd0 : fr_id_q;
    fr_len_e    = start ? 32'd0 : fr_len_q;
    body_e      = start ? 32'd0 : body_q;
    match_e     = start ? 1'b0  : match_q;
    txt_stop_e  = start ? 1'b0  : txt_stop_q;
    found_e     = start ? 1'b0  : found_q;
    scan_stop_e = start ? 1'b0  : scan_stop_q;
  end

  assign pos_plus10 = {1'b0, tag_pos_e} + {1'b0, FrameHdrLen};
  assign limit      = tag_len_e - fr_off_e - FrameHdrLen;

  always_comb begin
    phase_d     = phase_e_w;
    hdr_idx_d   = hdr_idx_e;
    major4_d    = major4_e;
    tag_len_d   = tag_len_e;
    tag_pos_d   = tag_pos_e;
    fr_off_d    = fr_off_e;
    fh_idx_d    = fh_idx_e;
    fr_id_d     = fr_id_e;
    fr_len_d    = fr_len_e;
    body_d      = body_e;
    match_d     = match_e;
    txt_stop_d  = txt_stop_e;
    found_d     = found_e;
    scan_stop_d = scan_stop_e;
    active      = 1'b0;
    done        = 1'b0;
    tv          = 1'b0;
    st          = ST_FOUND;
    bad_magic   = ((hdr_idx_e == HdrMagic0) && (b != CharI)) ||
                  ((hdr_idx_e == HdrMagic1) && (b != CharD)) ||
                  ((hdr_idx_e == HdrMagic2) && (b != Char3));

    unique case (phase_e_w)
      PH_HEADER: begin
        active = 1'b1;
        if (bad_magic) begin
          done = 1'b1;
          st   = ST_NO_TAG;
        end else begin
          if (hdr_idx_e == HdrMajor) begin
            major4_d = (b == MajorFour);
          end
          if (hdr_idx_e >= HdrSize0) begin
            tag_len_d = {tag_len_e[20:0], b[6:0] & SyncMask};
          end
          hdr_idx_d = hdr_idx_e + 4'd1;
          if (hdr_idx_e == HdrLast) begin
            phase_d = PH_TAG;
            if (tag_len_d == 28'd0) begin
              done = 1'b1;
              st   = ST_NOT_FOUND;
            end
          end
        end
      end
      PH_TAG: begin
        active = 1'b1;
        if (!scan_stop_e) begin
          if (body_e != 32'd0) begin
            body_d = body_e - 32'd1;
          end else if (fh_idx_e == FhIdFirst) begin
            // stop at padding or when no room is left for another frame
            if ((pos_plus10 >= {1'b0, tag_len_e}) || (b == 8'd0)) begin
              scan_stop_d = 1'b1;
            end else begin
              fr_off_d = tag_pos_e;
              fr_id_d  = {24'd0, b};
              fr_len_d = 32'd0;
              fh_idx_d = 4'd1;
            end
          end else if (fh_idx_e < FhIdEnd) begin
            fr_id_d  = {fr_id_e[23:0], b};
            fh_idx_d = fh_idx_e + 4'd1;
          end else if (fh_idx_e < FhSizeEnd) begin
            fr_len_d = major4_e ? {fr_len_e[24:0], b[6:0] & SyncMask}
                                : {fr_len_e[23:0], b};
            fh_idx_d = fh_idx_e + 4'd1;
          end else if (fh_idx_e == FhSizeEnd) begin
            fh_idx_d = fh_idx_e + 4'd1;
          end else begin
            fh_idx_d = FhIdFirst;
            if ((fr_len_e == 32'd0) || (fr_len_e > {4'd0, limit})) begin
              scan_stop_d = 1'b1;
            end else if ((fr_id_e == target_i) && (fr_len_e > 32'd1)) begin
              found_d     = 1'b1;
              match_d     = 1'b1;
              scan_stop_d = 1'b1;
              body_d      = fr_len_e;
            end else begin
              body_d = fr_len_e;
            end
          end
        end else if (match_e && (body_e != 32'd0)) begin
          body_d = body_e - 32'd1;
          // skip the encoding byte, emit up to the first zero
          if ((body_e != fr_len_e) && !txt_stop_e) begin
            if (b == 8'd0) begin
              txt_stop_d = 1'b1;
            end else begin
              tv = 1'b1;
            end
          end
        end
        tag_pos_d = tag_pos_e + 28'd1;
        if (tag_pos_d == tag_len_e) begin
          done = 1'b1;
          st   = found_d ? ST_FOUND : ST_NOT_FOUND;
        end
      end
      default: begin
        active = 1'b0;
      end
    endcase

    if (active && !done && item_i.file_end) begin
      done = 1'b1;
      st   = ST_TRUNC;
    end
    if (done) begin
      phase_d = PH_DONE;
    end
  end

  assign res_valid_o      = done | tv;
  assign res_o.text_byte  = tv ? b : 8'd0;
  assign res_o.text_valid = tv;
  assign res_o.done_res   = done;
  assign res_o.status     = done ? st : ST_FOUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_idx_q   <= 4'd0;
      major4_q    <= 1'b0;
      tag_len_q   <= 28'd0;
      tag_pos_q   <= 28'd0;
      fr_off_q    <= 28'd0;
      fh_idx_q    <= 4'd0;
      fr_id_q     <= 32'd0;
      fr_len_q    <= 32'd0;
      body_q      <= 32'd0;
      match_q     <= 1'b0;
      txt_stop_q  <= 1'b0;
      found_q     <= 1'b0;
      scan_stop_q <= 1'b0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      major4_q    <= major4_d;
      tag_len_q   <= tag_len_d;
      tag_pos_q   <= tag_pos_d;
      fr_off_q    <= fr_off_d;
      fh_idx_q    <= fh_idx_d;
      fr_id_q     <= fr_id_d;
      fr_len_q    <= fr_len_d;
      body_q      <= body_d;
      match_q     <= match_d;
      txt_stop_q  <= txt_stop_d;
      found_q     <= found_d;
      scan_stop_q <= scan_stop_d;
    end
  end

`ifndef SYNTHESIS
  a_done_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.done_res |=> phase_q == PH_DONE)
    else $error("final status did not park the parser");

  a_text_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_o.text_valid |->
      !start && phase_q == PH_TAG && match_q && scan_stop_q && !txt_stop_q)
    else $error("text byte outside the matched frame body");

  a_fh_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_idx_q <= FhFlagLast)
    else $error("frame header index out of range");

  a_match_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> found_q && scan_stop_q)
    else $error("match without found and stopped scan");
`endif

endmodule

@@ rtl/core/id3v2_text_frame_extractor_top.sv @@
// Top level of the ID3v2 text frame extractor: input register, parser,
// result register and APB config. Depends on id3tfe_pkg, id3tfe_cfg, id3tfe_parser.
`timescale 1ns / 1ps

// Feed the file one byte per transaction, file_start on the first byte. The
// block takes one byte every cycle while in_stall_o is low; a byte is held in
// the input register, passes through the combinational parser, and its result
// is captured in the result register when the parser advances. The input
// stalls only while a result waits in the result register with out_stall_i
// high. Each file ends in one result with done_res set and a status: found,
// not found, no tag, or truncated. Text bytes arrive before or with that
// result and are to be dropped unless the status is found. Write
// target_frame_id only while no file is in flight.
module id3v2_text_frame_extractor_top import id3tfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        s1_valid_q, s1_valid_d;
  in_item_t    s1_item_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  logic        out_free, advance, in_accept, res_valid;
  out_item_t   res;
  logic [31:0] target;

  id3tfe_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .target_o (target)
  );

  id3tfe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_item_q),
    .target_i    (target),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q & out_stall_i;
    if (advance) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule
